// ===== rtl/core/r16dc_pkg.sv =====
// ----------------------------------------------------------------------------
// r16dc_pkg
// Types, control word constants and decode tables shared by the decode
// and program counter control unit.
// ----------------------------------------------------------------------------
`default_nettype none

package r16dc_pkg;

    localparam int unsigned INSTR_W = 16;
    localparam int unsigned FLAGS_W = 4;
    localparam int unsigned PC_W    = 16;
    localparam int unsigned CW_W    = 10;
    localparam int unsigned REG_W   = 4;
    localparam int unsigned IMM_W   = 8;

    // packed stream widths, rounded up to whole bytes
    localparam int unsigned IN_BITS    = INSTR_W + FLAGS_W + PC_W;
    localparam int unsigned IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_BITS   = CW_W + 3 * REG_W + IMM_W + PC_W + 1;
    localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // major opcodes
    localparam logic [3:0] OP_REG   = 4'd0;
    localparam logic [3:0] OP_JUMP  = 4'd4;
    localparam logic [3:0] OP_SHIFT = 4'd8;
    localparam logic [3:0] OP_BCOND = 4'd12;
    localparam logic [3:0] OP_LUI   = 4'd15;

    // extensions of the jump group
    localparam logic [3:0] EXT_J0    = 4'd0;
    localparam logic [3:0] EXT_J4    = 4'd4;
    localparam logic [3:0] EXT_JAL   = 4'd8;
    localparam logic [3:0] EXT_JCOND = 4'd12;

    // condition codes
    localparam logic [3:0] CC_EQ = 4'd0;
    localparam logic [3:0] CC_NE = 4'd1;
    localparam logic [3:0] CC_CS = 4'd2;
    localparam logic [3:0] CC_CC = 4'd3;
    localparam logic [3:0] CC_GT = 4'd6;
    localparam logic [3:0] CC_LE = 4'd7;
    localparam logic [3:0] CC_LT = 4'd12;
    localparam logic [3:0] CC_GE = 4'd13;

    // fixed control words
    localparam logic [CW_W-1:0] CW_NOP = 10'h027;
    localparam logic [CW_W-1:0] CW_JAL = 10'h326;
    localparam logic [CW_W-1:0] CW_LUI = 10'h213;
    localparam logic [CW_W-1:0] CW_JC0 = 10'h11E;
    localparam logic [CW_W-1:0] CW_BC0 = 10'h016;
    localparam logic [CW_W-1:0] CW_J0  = 10'h054;
    localparam logic [CW_W-1:0] CW_J4  = 10'h095;

    // decode result handed to the state registers
    typedef struct packed {
        logic            known;
        logic [CW_W-1:0] cw;
        logic [PC_W-1:0] pc;
    } t_dec_res;

    // register-register group; zero marks an unused extension
    function automatic logic [CW_W-1:0] reg_op_cw(input logic [3:0] ext);
        logic [CW_W-1:0] cw;
        case (ext)
            4'd1:    cw = 10'h307;
            4'd2:    cw = 10'h309;
            4'd3:    cw = 10'h30B;
            4'd5:    cw = 10'h301;
            4'd9:    cw = 10'h303;
            4'd11:   cw = 10'h105;
            4'd13:   cw = 10'h30D;
            default: cw = '0;
        endcase
        return cw;
    endfunction

    // immediate group, indexed by opcode; zero marks an unused opcode
    function automatic logic [CW_W-1:0] imm_op_cw(input logic [3:0] op);
        logic [CW_W-1:0] cw;
        case (op)
            4'd1:    cw = 10'h308;
            4'd2:    cw = 10'h30A;
            4'd3:    cw = 10'h30C;
            4'd5:    cw = 10'h302;
            4'd9:    cw = 10'h304;
            4'd11:   cw = 10'h106;
            4'd13:   cw = 10'h30E;
            default: cw = '0;
        endcase
        return cw;
    endfunction

    function automatic logic [CW_W-1:0] shift_op_cw(input logic [1:0] sel);
        logic [CW_W-1:0] cw;
        case (sel)
            2'd0:    cw = 10'h310;
            2'd1:    cw = 10'h312;
            2'd2:    cw = 10'h30F;
            default: cw = 10'h311;
        endcase
        return cw;
    endfunction

    // {valid, offset from the EQ control word}
    function automatic logic [3:0] cond_slot(input logic [3:0] code);
        logic [3:0] s;
        case (code)
            CC_EQ:   s = 4'b1_000;
            CC_NE:   s = 4'b1_001;
            CC_CS:   s = 4'b1_011;
            CC_CC:   s = 4'b1_100;
            CC_GT:   s = 4'b1_101;
            CC_LE:   s = 4'b1_110;
            CC_LT:   s = 4'b1_111;
            CC_GE:   s = 4'b1_010;
            default: s = 4'b0_000;
        endcase
        return s;
    endfunction

    // flags: bit3 Z, bit2 F, bit1 N, bit0 C
    function automatic logic cond_true(input logic [3:0] code,
                                       input logic [FLAGS_W-1:0] flags);
        logic z;
        logic n;
        logic c;
        logic t;
        z = flags[3];
        n = flags[1];
        c = flags[0];
        case (code)
            CC_EQ:   t = z;
            CC_NE:   t = !z;
            CC_CS:   t = c;
            CC_CC:   t = !c;
            CC_GT:   t = n;
            CC_LE:   t = !n;
            CC_LT:   t = !n && !z;
            CC_GE:   t = z || n;
            default: t = 1'b0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/r16dc_decode.sv =====
// ----------------------------------------------------------------------------
// r16dc_decode
// Combinational decode of one instruction into the updated control word and
// program counter; unknown encodings keep the held values.
// ----------------------------------------------------------------------------
`default_nettype none

module r16dc_decode
    import r16dc_pkg::*;
(
    input  wire logic [INSTR_W-1:0] i_instr,
    input  wire logic [FLAGS_W-1:0] i_flags,
    input  wire logic [PC_W-1:0]    i_target,
    input  wire logic [PC_W-1:0]    i_pc,
    input  wire logic [CW_W-1:0]    i_held_cw,
    output t_dec_res                o_res
);

    logic [3:0]       w_op;
    logic [3:0]       w_rd;
    logic [3:0]       w_ext;
    logic [IMM_W-1:0] w_imm;
    logic [3:0]       w_slot;
    logic             w_taken;
    logic [PC_W-1:0]  w_inc;
    logic [PC_W-1:0]  w_branch;
    logic [CW_W-1:0]  w_cw;
    logic [PC_W-1:0]  w_npc;
    logic             w_known;

    assign w_op    = i_instr[15:12];
    assign w_rd    = i_instr[11:8];
    assign w_ext   = i_instr[7:4];
    assign w_imm   = i_instr[7:0];
    assign w_slot  = cond_slot(w_rd);
    assign w_taken = cond_true(w_rd, i_flags);

    // sequential and branch targets, both wrap at 16 bits
    assign w_inc    = i_pc + PC_W'(1);
    assign w_branch = i_pc + {{(PC_W-IMM_W){1'b0}}, w_imm};

    // opcode decode
    always_comb begin
        w_cw    = '0;
        w_npc   = w_inc;
        w_known = 1'b1;
        if (i_instr == '0) begin
            w_cw = CW_NOP;
        end else begin
            case (w_op)
                OP_REG: begin
                    w_cw    = reg_op_cw(w_ext);
                    w_known = (w_cw != '0);
                end
                OP_SHIFT: begin
                    w_cw    = shift_op_cw(i_instr[6:5]);
                    w_known = !i_instr[7];
                end
                OP_JUMP: begin
                    case (w_ext)
                        EXT_J0:  w_cw = CW_J0;
                        EXT_J4:  w_cw = CW_J4;
                        EXT_JAL: begin
                            w_cw  = CW_JAL;
                            w_npc = i_target;
                        end
                        EXT_JCOND: begin
                            w_cw    = CW_JC0 + {{(CW_W-3){1'b0}}, w_slot[2:0]};
                            w_known = w_slot[3];
                            if (w_taken) begin
                                w_npc = i_target;
                            end
                        end
                        default: w_known = 1'b0;
                    endcase
                end
                OP_BCOND: begin
                    w_cw    = CW_BC0 + {{(CW_W-3){1'b0}}, w_slot[2:0]};
                    w_known = w_slot[3];
                    if (w_taken) begin
                        w_npc = w_branch;
                    end
                end
                OP_LUI: w_cw = CW_LUI;
                default: begin
                    w_cw    = imm_op_cw(w_op);
                    w_known = (w_cw != '0);
                end
            endcase
        end
    end

    // unknown encodings leave PC and control word as they were
    assign o_res.known = w_known;
    assign o_res.cw    = w_known ? w_cw  : i_held_cw;
    assign o_res.pc    = w_known ? w_npc : i_pc;

endmodule

`default_nettype wire

// ===== rtl/core/r16dc_state.sv =====
// ----------------------------------------------------------------------------
// r16dc_state
// Program counter and held control word, updated once per decoded word.
// ----------------------------------------------------------------------------
`default_nettype none

module r16dc_state
    import r16dc_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_update,
    input  wire t_dec_res        i_res,
    output logic [PC_W-1:0]      o_pc,
    output logic [CW_W-1:0]      o_held_cw
);

    logic [PC_W-1:0] r_pc;
    logic [CW_W-1:0] r_held_cw;

    // decode already merges the keep-on-unknown rule
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_held_cw <= '0;
        end else if (i_update) begin
            r_pc      <= i_res.pc;
            r_held_cw <= i_res.cw;
        end
    end

    assign o_pc      = r_pc;
    assign o_held_cw = r_held_cw;

endmodule

`default_nettype wire

// ===== rtl/core/risc16_decode_and_pc_control_unit.sv =====
// ----------------------------------------------------------------------------
// risc16_decode_and_pc_control_unit
// Instruction decode and program counter control for a 16-bit processor.
//
// Usage:
//   Slave stream carries one word per instruction: instruction, status flags
//   (Z,F,N,C) and the register value used as jump target. Master stream
//   returns the control word, register indices, immediate, the updated PC
//   and an unknown-instruction flag.
//   On input accept the input register takes the word, then the decode and
//   PC adder load the result register once it is free or being read.
//   Throughput is one word per cycle while the receiver keeps up; the PC
//   and held control word are updated as each word moves into the result
//   register, so the following word decodes against them in the next cycle.
//   Reset clears the PC, the held control word and both valid flags.
//   When the receiver stalls, the result register holds, the input register
//   keeps one more word, and tready falls only while both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module risc16_decode_and_pc_control_unit
    import r16dc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [15:0] instruction, [19:16] status_flags, [35:20] target_value
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [9:0] control_word, [13:10] dest_reg, [17:14] src_reg,
    // [21:18] write_reg, [29:22] immediate, [45:30] next_pc, [46] unknown_instr
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    logic                  r_in_valid;
    logic [INSTR_W-1:0]    r_instr;
    logic [FLAGS_W-1:0]    r_flags;
    logic [PC_W-1:0]       r_target;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;
    logic                  w_in_take;
    logic                  w_adv;
    logic [PC_W-1:0]       w_pc;
    logic [CW_W-1:0]       w_held_cw;
    t_dec_res              w_res;

    // pipeline handshake
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_instr  <= i_s_axis_tdata[INSTR_W-1:0];
            r_flags  <= i_s_axis_tdata[INSTR_W +: FLAGS_W];
            r_target <= i_s_axis_tdata[INSTR_W+FLAGS_W +: PC_W];
        end
    end

    r16dc_decode u_decode (
        .i_instr   (r_instr),
        .i_flags   (r_flags),
        .i_target  (r_target),
        .i_pc      (w_pc),
        .i_held_cw (w_held_cw),
        .o_res     (w_res)
    );

    r16dc_state u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_update  (w_adv),
        .i_res     (w_res),
        .o_pc      (w_pc),
        .o_held_cw (w_held_cw)
    );

    // result packing
    assign n_out_data = {{(OUT_DATA_W-OUT_BITS){1'b0}},
                         !w_res.known,
                         w_res.pc,
                         r_instr[7:0],
                         r_instr[11:8],
                         r_instr[3:0],
                         r_instr[11:8],
                         w_res.cw};

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the decode and program counter control unit.
// A queue of instruction words (a directed opening, then mostly well-formed
// instructions with random content plus raw noise) feeds a bursty stream
// driver. Each accepted word is decoded by a local model that tracks its own
// PC and held control word. The monitor compares each result word, field by
// field, against the oldest prediction. The receiver stalls on its own
// pattern, holds off once for a long stretch, and the sender drains once.
// ----------------------------------------------------------------------------

module tb_top;
    import r16dc_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RANDOM_WORDS     = 1620;
    localparam int DRAIN_AT         = 900;
    localparam int CALM_FROM        = 1100;
    localparam int CALM_TO          = 1300;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int SETTLE_CYCLES    = 8;
    localparam int CYCLE_LIMIT      = 200000;

    // encodings with no defined meaning
    localparam logic [3:0] EXT_REG_NONE  = 4'd0;
    localparam logic [3:0] EXT_JUMP_NONE = 4'd15;
    localparam logic [2:0] SHIFT_SEL_BAD = 3'd4;
    localparam logic [3:0] CC_NONE_LO    = 4'd4;
    localparam logic [3:0] CC_NONE_HI    = 4'd15;

    // control word tables, entry 0 in the lowest bits; zero marks a hole
    localparam logic [16*CW_W-1:0] ALU_REG_CW = {
        10'h000, 10'h000, 10'h30D, 10'h000, 10'h105, 10'h000, 10'h303, 10'h000,
        10'h000, 10'h000, 10'h301, 10'h000, 10'h30B, 10'h309, 10'h307, 10'h000};
    localparam logic [16*CW_W-1:0] ALU_IMM_CW = {
        10'h000, 10'h000, 10'h30E, 10'h000, 10'h106, 10'h000, 10'h304, 10'h000,
        10'h000, 10'h000, 10'h302, 10'h000, 10'h30C, 10'h30A, 10'h308, 10'h000};
    localparam logic [4*CW_W-1:0] SHIFT_CW = {10'h311, 10'h30F, 10'h312, 10'h310};

    typedef struct packed {
        logic [INSTR_W-1:0] instr;
        logic [FLAGS_W-1:0] flags;
        logic [PC_W-1:0]    target;
    } in_word_t;

    typedef struct packed {
        logic [CW_W-1:0]  cw;
        logic [REG_W-1:0] rd;
        logic [REG_W-1:0] rs;
        logic [REG_W-1:0] wr;
        logic [IMM_W-1:0] imm;
        logic [PC_W-1:0]  npc;
        logic             unk;
    } dec_out_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tready = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;

    in_word_t instr_queue[$];
    dec_out_t decode_results_due[$];
    in_word_t word_on_bus;

    // decoder model state
    logic [PC_W-1:0] pc_model;
    logic [CW_W-1:0] cw_held_model;

    int acc_count = 0;
    int res_count = 0;
    int launched = 0;
    int n_directed = 0;
    int n_redirects = 0;
    int n_unknown = 0;
    int n_mismatch = 0;
    int cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    logic drain_hold = 1'b0;
    logic drain_done = 1'b0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    logic [7:0] stall_phase = '0;

    risc16_decode_and_pc_control_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // offset of a condition code from the EQ control word, -1 if unused
    function automatic int cond_offset(input logic [3:0] code);
        case (code)
            CC_EQ:   return 0;
            CC_NE:   return 1;
            CC_GE:   return 2;
            CC_CS:   return 3;
            CC_CC:   return 4;
            CC_GT:   return 5;
            CC_LE:   return 6;
            CC_LT:   return 7;
            default: return -1;
        endcase
    endfunction

    // condition tests as the processor defines them; F is never looked at
    function automatic logic cond_met(input logic [3:0] code,
                                      input logic [FLAGS_W-1:0] flags);
        logic z;
        logic n;
        logic c;
        z = flags[3];
        n = flags[1];
        c = flags[0];
        case (code)
            CC_EQ:   return z;
            CC_NE:   return !z;
            CC_CS:   return c;
            CC_CC:   return !c;
            CC_GT:   return n;
            CC_LE:   return !n;
            CC_LT:   return !n && !z;
            CC_GE:   return z || n;
            default: return 1'b0;
        endcase
    endfunction

    // decode one accepted word, advance the model PC, queue the result
    task automatic predict_decode(input in_word_t w);
        logic [3:0]      op;
        logic [3:0]      rd;
        logic [3:0]      ext;
        logic [7:0]      imm;
        logic [PC_W-1:0] inc;
        logic [PC_W-1:0] npc;
        logic [CW_W-1:0] cw;
        logic            known;
        int              slot;
        dec_out_t        r;
        op    = w.instr[15:12];
        rd    = w.instr[11:8];
        ext   = w.instr[7:4];
        imm   = w.instr[7:0];
        inc   = pc_model + 16'd1;
        npc   = inc;
        cw    = '0;
        known = 1'b1;
        if (w.instr == '0) begin
            cw = CW_NOP;
        end else begin
            case (op)
                OP_REG: begin
                    cw = ALU_REG_CW[ext*CW_W +: CW_W];
                    known = (cw != '0);
                end
                OP_SHIFT: begin
                    if (w.instr[7:5] < SHIFT_SEL_BAD) begin
                        cw = SHIFT_CW[w.instr[6:5]*CW_W +: CW_W];
                    end else begin
                        known = 1'b0;
                    end
                end
                OP_JUMP: begin
                    slot = cond_offset(rd);
                    case (ext)
                        EXT_J0: cw = CW_J0;
                        EXT_J4: cw = CW_J4;
                        EXT_JAL: begin
                            cw  = CW_JAL;
                            npc = w.target;
                        end
                        EXT_JCOND: begin
                            if (slot < 0) begin
                                known = 1'b0;
                            end else begin
                                cw = CW_JC0 + CW_W'(slot);
                                if (cond_met(rd, w.flags)) npc = w.target;
                            end
                        end
                        default: known = 1'b0;
                    endcase
                end
                OP_BCOND: begin
                    slot = cond_offset(rd);
                    if (slot < 0) begin
                        known = 1'b0;
                    end else begin
                        cw = CW_BC0 + CW_W'(slot);
                        if (cond_met(rd, w.flags)) npc = pc_model + {8'h00, imm};
                    end
                end
                OP_LUI: cw = CW_LUI;
                default: begin
                    cw = ALU_IMM_CW[op*CW_W +: CW_W];
                    known = (cw != '0);
                end
            endcase
        end
        // an unrecognised word leaves PC and held control untouched
        if (known) begin
            if (npc != inc) n_redirects++;
            cw_held_model = cw;
            pc_model      = npc;
        end else begin
            n_unknown++;
        end
        r.cw  = cw_held_model;
        r.rd  = rd;
        r.rs  = w.instr[3:0];
        r.wr  = rd;
        r.imm = imm;
        r.npc = pc_model;
        r.unk = !known;
        decode_results_due.push_back(r);
    endtask

    task automatic queue_word(input logic [15:0] ins, input logic [3:0] flags,
                              input logic [15:0] target);
        in_word_t w;
        w.instr  = ins;
        w.flags  = flags;
        w.target = target;
        instr_queue.push_back(w);
    endtask

    // mostly well-formed instructions with random content, some raw noise
    task automatic rand_instr(output logic [15:0] ins);
        int         r;
        logic [3:0] op;
        logic [3:0] code;
        logic [3:0] rd;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            do code = 4'($urandom); while (ALU_REG_CW[code*CW_W +: CW_W] == '0);
            ins = {OP_REG, 4'($urandom), code, 4'($urandom)};
        end else if (r < 28) begin
            do op = 4'($urandom); while (ALU_IMM_CW[op*CW_W +: CW_W] == '0);
            ins = {op, 12'($urandom)};
        end else if (r < 36) begin
            ins = {OP_SHIFT, 4'($urandom), 3'($urandom_range(0, 3)), 5'($urandom)};
        end else if (r < 56) begin
            case ($urandom_range(0, 3))
                0:       code = EXT_J0;
                1:       code = EXT_J4;
                2:       code = EXT_JAL;
                default: code = EXT_JCOND;
            endcase
            rd = 4'($urandom);
            if (code == EXT_JCOND && $urandom_range(0, 9) != 0) begin
                while (cond_offset(rd) < 0) rd = 4'($urandom);
            end
            ins = {OP_JUMP, rd, code, 4'($urandom)};
        end else if (r < 76) begin
            rd = 4'($urandom);
            if ($urandom_range(0, 9) != 0) begin
                while (cond_offset(rd) < 0) rd = 4'($urandom);
            end
            ins = {OP_BCOND, rd, 8'($urandom)};
        end else if (r < 82) begin
            ins = {OP_LUI, 12'($urandom)};
        end else if (r < 86) begin
            ins = '0;
        end else begin
            ins = 16'($urandom);
        end
    endtask

    // mismatch bookkeeping, only the first few are printed
    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("tb_top: result %0d %s expected %h got %h",
                         res_count, name, exp_v, act_v);
        end
    endtask

    // stimulus and end of run
    initial begin
        logic [15:0] ins;
        pc_model      = '0;
        cw_held_model = '0;

        // every major opcode once, random low bits
        for (int op = 0; op < 16; op++)
            queue_word({4'(op), 12'($urandom)}, 4'($urandom), 16'($urandom));
        queue_word(16'h0000, 4'h0, 16'h0000);
        queue_word(16'hFFFF, 4'hF, 16'hFFFF);
        queue_word({OP_REG, 4'hA, EXT_REG_NONE, 4'h5}, 4'h0, 16'h0000);
        queue_word({OP_SHIFT, 4'h3, SHIFT_SEL_BAD, 5'h1F}, 4'h0, 16'h0000);
        queue_word({OP_JUMP, 4'h1, EXT_JUMP_NONE, 4'h2}, 4'h0, 16'h0000);
        queue_word({OP_JUMP, CC_NONE_LO, EXT_JCOND, 4'h0}, 4'hF, 16'hABCD);
        queue_word({OP_BCOND, CC_NONE_HI, 8'hFF}, 4'hF, 16'h0000);
        // PC wraps on increment and on a taken branch
        queue_word({OP_JUMP, 4'h0, EXT_JAL, 4'h7}, 4'h0, 16'hFFFF);
        queue_word(16'h0000, 4'h0, 16'h0000);
        queue_word({OP_JUMP, 4'h0, EXT_JAL, 4'h7}, 4'h0, 16'hFFF0);
        queue_word({OP_BCOND, CC_EQ, 8'hFF}, 4'h8, 16'h0000);
        queue_word({OP_BCOND, CC_NE, 8'h10}, 4'h8, 16'h0000);
        queue_word({OP_JUMP, CC_LT, EXT_JCOND, 4'h1}, 4'h0, 16'h1234);
        queue_word({OP_JUMP, CC_GE, EXT_JCOND, 4'h1}, 4'h0, 16'h4321);
        n_directed = instr_queue.size();

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            rand_instr(ins);
            queue_word(ins, 4'($urandom), 16'($urandom));
        end

        do @(posedge clk);
        while (!(rst_n && instr_queue.size() == 0 && !s_tvalid && acc_count == res_count));
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (decode_results_due.size() != 0)
            $display("tb_top: %0d results never arrived", decode_results_due.size());
        $display("tb_top: %0d words (%0d directed), %0d PC redirects, %0d unrecognised",
                 acc_count, n_directed, n_redirects, n_unknown);
        $display("tb_top: long receiver hold-off %0s, sender drain pause %0s",
                 hold_done ? "done" : "missed", drain_done ? "done" : "missed");
        if (n_mismatch == 0 && decode_results_due.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // stream driver: bursts with gaps, one pause until all results are back
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_decode(word_on_bus);
                acc_count <= acc_count + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (drain_hold) begin
                    s_tvalid <= 1'b0;
                    if (!s_tvalid && acc_count == res_count) begin
                        drain_hold <= 1'b0;
                        drain_done <= 1'b1;
                    end
                end else if (instr_queue.size() > 0) begin
                    word_on_bus <= instr_queue[0];
                    s_tdata     <= {4'b0, instr_queue[0].target, instr_queue[0].flags,
                                    instr_queue[0].instr};
                    s_tvalid    <= 1'b1;
                    void'(instr_queue.pop_front());
                    launched <= launched + 1;
                    if (launched + 1 == DRAIN_AT) drain_hold <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        if (launched >= CALM_FROM && launched < CALM_TO)
                            gap_left <= 0;
                        else
                            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready pattern, with one long hold-off counted here
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= (hold_left == 1);
            if (hold_left == 1) hold_done <= 1'b1;
        end else if (!hold_done && res_count >= LONG_HOLD_AT) begin
            hold_left <= LONG_HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            stall_phase <= stall_phase + 8'd1;
            case (stall_phase[7:6])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // result monitor
    always @(posedge clk) begin
        dec_out_t e;
        if (rst_n && m_tvalid && m_tready) begin
            if (decode_results_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("tb_top: unexpected result word %h", m_tdata);
            end else begin
                e = decode_results_due.pop_front();
                check_field("control_word",  16'(e.cw),  16'(m_tdata[9:0]));
                check_field("dest_reg",      16'(e.rd),  16'(m_tdata[13:10]));
                check_field("src_reg",       16'(e.rs),  16'(m_tdata[17:14]));
                check_field("write_reg",     16'(e.wr),  16'(m_tdata[21:18]));
                check_field("immediate",     16'(e.imm), 16'(m_tdata[29:22]));
                check_field("next_pc",       e.npc,      m_tdata[45:30]);
                check_field("unknown_instr", 16'(e.unk), 16'(m_tdata[46]));
            end
            res_count <= res_count + 1;
        end
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycles);
            $display("tb_top: FAIL");
            $finish;
        end
    end

endmodule
